### rtl/sorted_priority_queue_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue
// Shared concurrent assertion forms, each clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Operation codes, default sizes and the compare unit result type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

   localparam int DEPTH_DEF    = 32;
   localparam int KEY_BITS_DEF = 16;
   localparam int ID_BITS_DEF  = 16;
   localparam int OP_BITS      = 3;

   localparam logic [OP_BITS-1:0] OP_OFFER     = 3'd0;
   localparam logic [OP_BITS-1:0] OP_POLL      = 3'd1;
   localparam logic [OP_BITS-1:0] OP_READ      = 3'd2;
   localparam logic [OP_BITS-1:0] OP_REMOVE_AT = 3'd3;
   localparam logic [OP_BITS-1:0] OP_REMOVE_ID = 3'd4;

   typedef struct packed {
      logic ranks_after;
      logic id_match;
   } cmp_result_type;

endpackage

`default_nettype wire

### rtl/spq_if.sv
// ----------------------------------------------------------------------------
// Sorted priority queue channels
// Request, response and control register write channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface spq_req_if #(
   parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF,
   parameter int ID_BITS  = spq_pkg::ID_BITS_DEF,
   parameter int POS_BITS = $clog2(spq_pkg::DEPTH_DEF)
) ();
   logic                         valid;
   logic                         ready;
   logic [spq_pkg::OP_BITS-1:0]  op;
   logic [KEY_BITS-1:0]          key;
   logic [ID_BITS-1:0]           item_id;
   logic [POS_BITS-1:0]          position;

   modport source (output valid, op, key, item_id, position, input ready);
   modport sink   (input valid, op, key, item_id, position, output ready);
endinterface

interface spq_rsp_if #(
   parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF,
   parameter int ID_BITS  = spq_pkg::ID_BITS_DEF,
   parameter int POS_BITS = $clog2(spq_pkg::DEPTH_DEF),
   parameter int CNT_BITS = $clog2(spq_pkg::DEPTH_DEF + 1)
) ();
   logic                valid;
   logic                ready;
   logic                found;
   logic [POS_BITS-1:0] insert_position;
   logic [ID_BITS-1:0]  out_id;
   logic [KEY_BITS-1:0] out_key;
   logic [CNT_BITS-1:0] removed_count;
   logic [CNT_BITS-1:0] entry_count;
   logic                full_reject;

   modport source (output valid, found, insert_position, out_id, out_key, removed_count,
                   entry_count, full_reject, input ready);
   modport sink   (input valid, found, insert_position, out_id, out_key, removed_count,
                   entry_count, full_reject, output ready);
endinterface

interface spq_csr_if ();
   logic valid;
   logic ready;
   logic data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### rtl/spq_cmp.sv
// ----------------------------------------------------------------------------
// Sorted priority queue compare unit
// Ranks the request key against one stored key and matches item ids.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_cmp #(
   parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF,
   parameter int ID_BITS  = spq_pkg::ID_BITS_DEF
) (
   input  logic                    largest_first,
   input  logic [KEY_BITS-1:0]     key_new,
   input  logic [KEY_BITS-1:0]     key_stored,
   input  logic [ID_BITS-1:0]      id_new,
   input  logic [ID_BITS-1:0]      id_stored,
   output spq_pkg::cmp_result_type result
);
   import spq_pkg::*;

   // The new entry ranks after the stored one when it is strictly worse.
   assign result.ranks_after = largest_first ? (key_new < key_stored)
                                             : (key_new > key_stored);
   assign result.id_match    = (id_new == id_stored);

endmodule

`default_nettype wire

### rtl/spq_store.sv
// ----------------------------------------------------------------------------
// Sorted priority queue entry store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_store #(
   parameter int DEPTH    = spq_pkg::DEPTH_DEF,
   parameter int WIDTH    = spq_pkg::KEY_BITS_DEF + spq_pkg::ID_BITS_DEF,
   localparam int POS_BITS = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [POS_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]    wr_data,
   input  logic [POS_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]    rd_data
);
   import spq_pkg::*;

   logic [WIDTH-1:0] entry_mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/spq_seq.sv
// ----------------------------------------------------------------------------
// Sorted priority queue sequencer
// Walks the entry store one position a cycle where a request needs it and holds
// the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_seq #(
   parameter int DEPTH    = spq_pkg::DEPTH_DEF,
   parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF,
   parameter int ID_BITS  = spq_pkg::ID_BITS_DEF,
   localparam int POS_BITS = $clog2(DEPTH),
   localparam int EW       = KEY_BITS + ID_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                largest_first,
   spq_req_if.sink             req_bus,
   spq_rsp_if.source           rsp_bus,
   output logic                st_wr_en,
   output logic [POS_BITS-1:0] st_wr_addr,
   output logic [EW-1:0]       st_wr_data,
   output logic [POS_BITS-1:0] st_rd_addr,
   input  logic [EW-1:0]       st_rd_data
);
   import spq_pkg::*;

   localparam int CNT_BITS = $clog2(DEPTH + 1);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SCAN    = 3'd1;
   localparam logic [2:0] S_SHIFT   = 3'd2;
   localparam logic [2:0] S_FETCH   = 3'd3;
   localparam logic [2:0] S_DROP    = 3'd4;
   localparam logic [2:0] S_COMPACT = 3'd5;
   localparam logic [2:0] S_FINISH  = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [OP_BITS-1:0]  op_ff, op_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [ID_BITS-1:0]  id_ff, id_in;
   logic [CNT_BITS-1:0] idx_ff, idx_in;
   logic [CNT_BITS-1:0] jdx_ff, jdx_in;
   logic                found_ff, found_in;
   logic [POS_BITS-1:0] ins_ff, ins_in;
   logic [ID_BITS-1:0]  oid_ff, oid_in;
   logic [KEY_BITS-1:0] okey_ff, okey_in;
   logic [CNT_BITS-1:0] rem_ff, rem_in;
   logic                rej_ff, rej_in;

   logic                out_found_ff, out_found_in;
   logic [POS_BITS-1:0] out_ins_ff, out_ins_in;
   logic [ID_BITS-1:0]  out_id_ff, out_id_in;
   logic [KEY_BITS-1:0] out_key_ff, out_key_in;
   logic [CNT_BITS-1:0] out_rem_ff, out_rem_in;
   logic [CNT_BITS-1:0] out_count_ff, out_count_in;
   logic                out_rej_ff, out_rej_in;

   logic [KEY_BITS-1:0] rd_key;
   logic [ID_BITS-1:0]  rd_id;
   logic [POS_BITS-1:0] sel_pos;
   cmp_result_type      cmp;

   assign rd_key = st_rd_data[EW-1:ID_BITS];
   assign rd_id  = st_rd_data[ID_BITS-1:0];

   spq_cmp #(
      .KEY_BITS (KEY_BITS),
      .ID_BITS  (ID_BITS)
   ) u_cmp (
      .largest_first (largest_first),
      .key_new       (key_ff),
      .key_stored    (rd_key),
      .id_new        (id_ff),
      .id_stored     (rd_id),
      .result        (cmp)
   );

   assign sel_pos = (req_bus.op == OP_POLL) ? '0 : req_bus.position;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      id_in        = id_ff;
      idx_in       = idx_ff;
      jdx_in       = jdx_ff;
      found_in     = found_ff;
      ins_in       = ins_ff;
      oid_in       = oid_ff;
      okey_in      = okey_ff;
      rem_in       = rem_ff;
      rej_in       = rej_ff;
      out_found_in = out_found_ff;
      out_ins_in   = out_ins_ff;
      out_id_in    = out_id_ff;
      out_key_in   = out_key_ff;
      out_rem_in   = out_rem_ff;
      out_count_in = out_count_ff;
      out_rej_in   = out_rej_ff;
      st_wr_en     = 1'b0;
      st_wr_addr   = idx_ff[POS_BITS-1:0];
      st_wr_data   = st_rd_data;
      st_rd_addr   = '0;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               op_in    = req_bus.op;
               key_in   = req_bus.key;
               id_in    = req_bus.item_id;
               idx_in   = '0;
               jdx_in   = '0;
               found_in = 1'b0;
               ins_in   = '0;
               oid_in   = '0;
               okey_in  = '0;
               rem_in   = '0;
               rej_in   = 1'b0;
               unique case (req_bus.op) inside
                  OP_OFFER: begin
                     if (count_ff == CNT_BITS'(DEPTH)) begin
                        rej_in   = 1'b1;
                        state_in = S_FINISH;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_POLL, OP_READ, OP_REMOVE_AT: begin
                     if (CNT_BITS'(sel_pos) < count_ff) begin
                        st_rd_addr = sel_pos;
                        idx_in     = CNT_BITS'(sel_pos);
                        state_in   = S_FETCH;
                     end else begin
                        state_in = S_FINISH;
                     end
                  end
                  OP_REMOVE_ID: begin
                     state_in = S_COMPACT;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end

         // Front-to-back search for the first entry the new key does not rank after.
         S_SCAN: begin
            if ((idx_ff < count_ff) && cmp.ranks_after) begin
               idx_in     = idx_ff + 1'b1;
               st_rd_addr = POS_BITS'(idx_ff + 1'b1);
            end else begin
               jdx_in     = idx_ff;
               ins_in     = idx_ff[POS_BITS-1:0];
               idx_in     = count_ff;
               st_rd_addr = POS_BITS'(count_ff - 1'b1);
               state_in   = S_SHIFT;
            end
         end

         // Moves the tail up by one, back to front, then drops the new entry in.
         S_SHIFT: begin
            st_wr_en = 1'b1;
            if (idx_ff > jdx_ff) begin
               st_wr_addr = idx_ff[POS_BITS-1:0];
               st_wr_data = st_rd_data;
               idx_in     = idx_ff - 1'b1;
               st_rd_addr = POS_BITS'(idx_ff - CNT_BITS'(2));
            end else begin
               st_wr_addr = jdx_ff[POS_BITS-1:0];
               st_wr_data = {key_ff, id_ff};
               count_in   = count_ff + 1'b1;
               found_in   = 1'b1;
               state_in   = S_FINISH;
            end
         end

         S_FETCH: begin
            oid_in   = rd_id;
            okey_in  = rd_key;
            found_in = 1'b1;
            if (op_ff == OP_READ) begin
               state_in = S_FINISH;
            end else begin
               st_rd_addr = POS_BITS'(idx_ff + 1'b1);
               state_in   = S_DROP;
            end
         end

         // Closes the gap left by the removed entry, front to back.
         S_DROP: begin
            if (CNT_BITS'(idx_ff + 1'b1) < count_ff) begin
               st_wr_en   = 1'b1;
               st_wr_addr = idx_ff[POS_BITS-1:0];
               st_wr_data = st_rd_data;
               idx_in     = idx_ff + 1'b1;
               st_rd_addr = POS_BITS'(idx_ff + CNT_BITS'(2));
            end else begin
               count_in = count_ff - 1'b1;
               state_in = S_FINISH;
            end
         end

         // The read index runs ahead of the write index, so kept entries slide down.
         S_COMPACT: begin
            if (idx_ff < count_ff) begin
               if (cmp.id_match) begin
                  rem_in = rem_ff + 1'b1;
               end else begin
                  st_wr_en   = 1'b1;
                  st_wr_addr = jdx_ff[POS_BITS-1:0];
                  st_wr_data = st_rd_data;
                  jdx_in     = jdx_ff + 1'b1;
               end
               idx_in     = idx_ff + 1'b1;
               st_rd_addr = POS_BITS'(idx_ff + 1'b1);
            end else begin
               count_in = jdx_ff;
               found_in = (rem_ff != '0);
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               out_found_in = found_ff;
               out_ins_in   = ins_ff;
               out_id_in    = oid_ff;
               out_key_in   = okey_ff;
               out_rem_in   = rem_ff;
               out_count_in = count_ff;
               out_rej_in   = rej_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      id_ff        <= id_in;
      idx_ff       <= idx_in;
      jdx_ff       <= jdx_in;
      found_ff     <= found_in;
      ins_ff       <= ins_in;
      oid_ff       <= oid_in;
      okey_ff      <= okey_in;
      rem_ff       <= rem_in;
      rej_ff       <= rej_in;
      out_found_ff <= out_found_in;
      out_ins_ff   <= out_ins_in;
      out_id_ff    <= out_id_in;
      out_key_ff   <= out_key_in;
      out_rem_ff   <= out_rem_in;
      out_count_ff <= out_count_in;
      out_rej_ff   <= out_rej_in;
   end

   assign req_bus.ready           = (state_ff == S_IDLE);
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.found           = out_found_ff;
   assign rsp_bus.insert_position = out_ins_ff;
   assign rsp_bus.out_id          = out_id_ff;
   assign rsp_bus.out_key         = out_key_ff;
   assign rsp_bus.removed_count   = out_rem_ff;
   assign rsp_bus.entry_count     = out_count_ff;
   assign rsp_bus.full_reject     = out_rej_ff;

endmodule

`default_nettype wire

### rtl/sorted_priority_queue_core.sv
// ----------------------------------------------------------------------------
// Sorted priority queue core
// Requests offer, poll, read at a position, remove at a position or remove
// by id on a list of entries kept in priority order in a one-read, one-write store.
// Channels: req_bus takes one request, rsp_bus returns exactly one response
// for it, csr_bus writes the largest_first bit (always ready; write it only
// while no request is in flight).
// Steps per request: an offer scans for its slot, shifts the tail up and
// finishes; a poll or remove at a position fetches the entry, closes the
// gap and finishes; a read fetches and finishes; a remove by id compacts
// the whole list and finishes; a full offer, a miss or a bad op goes
// straight to finish. The sequencer handles one request at a time; the
// store's single read port moves one entry per cycle. req_bus.ready is
// high only while the sequencer is idle.
// Reset clears the entry count, the response valid flag and largest_first;
// the store itself needs no clearing. A finished response waits in its
// register while the receiver stalls; a later response holds the sequencer
// in its finish state until the waiting one is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_core #(
   parameter int DEPTH    = spq_pkg::DEPTH_DEF,
   parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF,
   parameter int ID_BITS  = spq_pkg::ID_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   spq_req_if.sink    req_bus,
   spq_rsp_if.source  rsp_bus,
   spq_csr_if.sink    csr_bus
);
   import spq_pkg::*;

   `include "sorted_priority_queue_core_assert.svh"

   localparam int POS_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam int EW       = KEY_BITS + ID_BITS;

   logic                largest_first_ff, largest_first_in;
   logic                st_wr_en;
   logic [POS_BITS-1:0] st_wr_addr;
   logic [EW-1:0]       st_wr_data;
   logic [POS_BITS-1:0] st_rd_addr;
   logic [EW-1:0]       st_rd_data;

   assign csr_bus.ready    = 1'b1;
   assign largest_first_in = (csr_bus.valid) ? csr_bus.data : largest_first_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         largest_first_ff <= 1'b0;
      end else begin
         largest_first_ff <= largest_first_in;
      end
   end

   spq_seq #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS),
      .ID_BITS  (ID_BITS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .largest_first (largest_first_ff),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .st_wr_en      (st_wr_en),
      .st_wr_addr    (st_wr_addr),
      .st_wr_data    (st_wr_data),
      .st_rd_addr    (st_rd_addr),
      .st_rd_data    (st_rd_data)
   );

   spq_store #(
      .DEPTH (DEPTH),
      .WIDTH (EW)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   `SPQ_ASSERT_NEXT(a_busy_after_request, clock, reset,
      req_bus.valid && req_bus.ready, !req_bus.ready,
      "request channel still ready after a request")
   `SPQ_ASSERT_NOW(a_count_bounded, clock, reset,
      rsp_bus.valid, rsp_bus.entry_count <= CNT_BITS'(DEPTH),
      "entry count beyond depth")
   `SPQ_ASSERT_NOW(a_reject_not_found, clock, reset,
      rsp_bus.valid && rsp_bus.full_reject, !rsp_bus.found,
      "rejected offer flagged as found")
   `SPQ_ASSERT_NOW(a_removed_found, clock, reset,
      rsp_bus.valid && (rsp_bus.removed_count != '0), rsp_bus.found,
      "removal by id not flagged as found")

endmodule

`default_nettype wire

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// Sorted priority queue core testbench
// Drives offer, poll, read, remove-at and remove-by-id requests with random
// gaps on both channels, keeps a shadow copy of the ordered entry list, and
// checks every response field by field against it or against a typed
// directed row. A short directed table opens the run, then episodes that
// fill, mix, drain and probe the queue under both head orderings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import spq_pkg::*;

   localparam int DEPTH    = DEPTH_DEF;
   localparam int KEY_BITS = KEY_BITS_DEF;
   localparam int ID_BITS  = ID_BITS_DEF;
   localparam int POS_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   localparam logic [OP_BITS-1:0] OP_RSVD_LO = 3'd5;
   localparam logic [OP_BITS-1:0] OP_RSVD_MID = 3'd6;
   localparam logic [OP_BITS-1:0] OP_RSVD_HI = 3'd7;

   localparam logic [KEY_BITS-1:0] KEY_MAX = '1;
   localparam logic [ID_BITS-1:0]  ID_MAX  = '1;

   localparam int CYCLE_LIMIT       = 1000000;
   localparam int LONG_HOLD_CYCLES  = 300;
   localparam int ITEMS_PER_PHASE   = 250;
   localparam int TAIL_CYCLES       = 60;
   localparam bit [3:0] ORDER_PLAN  = 4'b0101;

   typedef struct packed {
      logic [OP_BITS-1:0]  op;
      logic [KEY_BITS-1:0] key;
      logic [ID_BITS-1:0]  item_id;
      logic [POS_BITS-1:0] position;
   } queue_request_type;

   typedef struct packed {
      logic                found;
      logic [POS_BITS-1:0] insert_position;
      logic [ID_BITS-1:0]  out_id;
      logic [KEY_BITS-1:0] out_key;
      logic [CNT_BITS-1:0] removed_count;
      logic [CNT_BITS-1:0] entry_count;
      logic                full_reject;
   } queue_result_type;

   typedef struct packed {
      queue_request_type req;
      logic              typed;
      queue_result_type  res;
   } table_row_type;

   logic clock;
   logic reset;

   spq_req_if req_bus ();
   spq_rsp_if rsp_bus ();
   spq_csr_if csr_bus ();

   sorted_priority_queue_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Shadow of the entry list and the ordering bit.
   logic [KEY_BITS-1:0] shadow_keys [DEPTH];
   logic [ID_BITS-1:0]  shadow_ids  [DEPTH];
   int                  shadow_count = 0;
   logic                shadow_largest_first = 1'b0;

   queue_result_type pending_results [$];
   table_row_type    directed_rows [$];

   int   error_count = 0;
   int   cycle_count = 0;
   int   items_left = 0;
   bit   sender_calm = 1'b0;
   logic long_hold = 1'b0;
   event hold_trigger;

   int sink_stall_left = 0;
   int sink_mode_left = 0;
   bit sink_calm = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sorted_priority_queue_core regression: fail");
      $finish;
   end

   // Applies one accepted request to the shadow list and returns its response.
   function automatic queue_result_type apply_request(input queue_request_type r);
      queue_result_type res;
      int slot;
      int i;
      int kept;
      res = '0;
      case (r.op) inside
         OP_OFFER: begin
            if (shadow_count >= DEPTH) begin
               res.full_reject = 1'b1;
            end else begin
               slot = 0;
               while (slot < shadow_count &&
                      (shadow_largest_first ? r.key < shadow_keys[slot]
                                            : r.key > shadow_keys[slot]))
                  slot++;
               for (i = shadow_count; i > slot; i--) begin
                  shadow_keys[i] = shadow_keys[i - 1];
                  shadow_ids[i]  = shadow_ids[i - 1];
               end
               shadow_keys[slot] = r.key;
               shadow_ids[slot]  = r.item_id;
               shadow_count++;
               res.found = 1'b1;
               res.insert_position = POS_BITS'(slot);
            end
         end
         OP_POLL, OP_READ, OP_REMOVE_AT: begin
            slot = (r.op == OP_POLL) ? 0 : int'(r.position);
            if (slot < shadow_count) begin
               res.found   = 1'b1;
               res.out_id  = shadow_ids[slot];
               res.out_key = shadow_keys[slot];
               if (r.op != OP_READ) begin
                  for (i = slot; i + 1 < shadow_count; i++) begin
                     shadow_keys[i] = shadow_keys[i + 1];
                     shadow_ids[i]  = shadow_ids[i + 1];
                  end
                  shadow_count--;
               end
            end
         end
         OP_REMOVE_ID: begin
            kept = 0;
            for (i = 0; i < shadow_count; i++) begin
               if (shadow_ids[i] == r.item_id) begin
                  res.removed_count++;
               end else begin
                  shadow_keys[kept] = shadow_keys[i];
                  shadow_ids[kept]  = shadow_ids[i];
                  kept++;
               end
            end
            shadow_count = kept;
            res.found = (res.removed_count != 0);
         end
         default: ;
      endcase
      res.entry_count = CNT_BITS'(shadow_count);
      return res;
   endfunction

   function automatic table_row_type row(input logic [OP_BITS-1:0] op,
                                         input logic [KEY_BITS-1:0] key,
                                         input logic [ID_BITS-1:0] item_id,
                                         input logic [POS_BITS-1:0] position,
                                         input logic typed,
                                         input logic found,
                                         input logic [POS_BITS-1:0] ins,
                                         input logic [ID_BITS-1:0] oid,
                                         input logic [KEY_BITS-1:0] okey,
                                         input logic [CNT_BITS-1:0] removed,
                                         input logic [CNT_BITS-1:0] count,
                                         input logic reject);
      table_row_type t;
      t.req = '{op, key, item_id, position};
      t.typed = typed;
      t.res = '{found, ins, oid, okey, removed, count, reject};
      return t;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (sender_calm || roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [KEY_BITS-1:0] rand_key();
      case ($urandom_range(0, 3)) inside
         0, 1: return KEY_BITS'($urandom());
         2: return KEY_BITS'($urandom_range(0, 7));
         default: return $urandom_range(0, 1) ? KEY_MAX : '0;
      endcase
   endfunction

   function automatic logic [ID_BITS-1:0] rand_id();
      case ($urandom_range(0, 3))
         0: return ID_BITS'($urandom());
         1: return ID_BITS'($urandom_range(0, 3));
         2: return $urandom_range(0, 1) ? ID_MAX : '0;
         default: begin
            if (shadow_count > 0) return shadow_ids[$urandom_range(0, shadow_count - 1)];
            return ID_BITS'($urandom());
         end
      endcase
   endfunction

   function automatic queue_request_type rand_request(input logic [OP_BITS-1:0] op);
      queue_request_type r;
      r.op = op;
      r.key = rand_key();
      r.item_id = rand_id();
      if (shadow_count > 0 && $urandom_range(0, 3) != 0)
         r.position = POS_BITS'($urandom_range(0, shadow_count - 1));
      else
         r.position = POS_BITS'($urandom_range(0, DEPTH - 1));
      return r;
   endfunction

   function automatic logic [OP_BITS-1:0] pick_mixed_op();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return OP_OFFER;
      if (roll < 55) return OP_POLL;
      if (roll < 70) return OP_READ;
      if (roll < 85) return OP_REMOVE_AT;
      if (roll < 95) return OP_REMOVE_ID;
      return OP_BITS'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
   endfunction

   // Presents one request, holding valid high until it is taken; valid is
   // only lowered here when a gap precedes the request.
   task automatic send(input queue_request_type r, input logic typed,
                       input queue_result_type typed_res);
      int gap;
      queue_result_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.op       <= r.op;
      req_bus.key      <= r.key;
      req_bus.item_id  <= r.item_id;
      req_bus.position <= r.position;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predicted = apply_request(r);
      pending_results.push_back(typed ? typed_res : predicted);
      if (r.op <= OP_REMOVE_ID) items_left--;
   endtask

   task automatic send_random(input queue_request_type r);
      send(r, 1'b0, '0);
   endtask

   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_largest_first(input logic value);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      shadow_largest_first = value;
      csr_bus.valid <= 1'b0;
   endtask

   task automatic run_episode();
      int kind;
      int pool;
      int i;
      logic [ID_BITS-1:0] base_id;
      queue_request_type r;
      kind = $urandom_range(0, 9);
      sender_calm = ($urandom_range(0, 4) == 0);
      if (kind < 3) begin
         // Fill to capacity from a small set of ids, push past full, and
         // sometimes clear the set again by id.
         pool = $urandom_range(1, 4);
         base_id = ID_BITS'($urandom());
         while (shadow_count < DEPTH) begin
            r = rand_request(OP_OFFER);
            r.item_id = base_id + ID_BITS'($urandom_range(0, pool - 1));
            send_random(r);
         end
         repeat ($urandom_range(1, 3)) send_random(rand_request(OP_OFFER));
         if ($urandom_range(0, 1) == 1) begin
            for (i = 0; i < pool; i++) begin
               r = rand_request(OP_REMOVE_ID);
               r.item_id = base_id + ID_BITS'(i);
               send_random(r);
            end
         end
      end else if (kind < 7) begin
         repeat ($urandom_range(20, 60)) send_random(rand_request(pick_mixed_op()));
      end else if (kind < 9) begin
         while (shadow_count > 0)
            send_random(rand_request($urandom_range(0, 1) ? OP_POLL : OP_REMOVE_AT));
         send_random(rand_request(pick_mixed_op()));
      end else begin
         repeat ($urandom_range(3, 8)) begin
            r = rand_request(pick_mixed_op());
            if (r.op == OP_READ || r.op == OP_REMOVE_AT)
               r.position = POS_BITS'($urandom_range(shadow_count < DEPTH ? shadow_count : 0,
                                                      DEPTH - 1));
            send_random(r);
         end
      end
      if ($urandom_range(0, 3) == 0) wait_for_results();
   endtask

   // Response side: checks each taken response and chooses the next ready.
   always @(posedge clock) begin
      queue_result_type expected;
      queue_result_type actual;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            actual = '{rsp_bus.found, rsp_bus.insert_position, rsp_bus.out_id,
                       rsp_bus.out_key, rsp_bus.removed_count, rsp_bus.entry_count,
                       rsp_bus.full_reject};
            if (pending_results.size() == 0) begin
               $display("%0t: response with no request outstanding: %h", $time, actual);
               error_count++;
            end else begin
               expected = pending_results.pop_front();
               if (actual !== expected) begin
                  $display("%0t: response mismatch, expected / actual:", $time);
                  $display("   found %h / %h, insert_position %h / %h",
                           expected.found, actual.found,
                           expected.insert_position, actual.insert_position);
                  $display("   out_id %h / %h, out_key %h / %h",
                           expected.out_id, actual.out_id, expected.out_key, actual.out_key);
                  $display("   removed_count %h / %h, entry_count %h / %h",
                           expected.removed_count, actual.removed_count,
                           expected.entry_count, actual.entry_count);
                  $display("   full_reject %h / %h", expected.full_reject, actual.full_reject);
                  error_count++;
               end
            end
         end
         if (sink_mode_left == 0) begin
            sink_calm = ($urandom_range(0, 3) == 0);
            sink_mode_left = $urandom_range(100, 300);
         end else begin
            sink_mode_left--;
         end
         if (long_hold) begin
            rsp_bus.ready <= 1'b0;
         end else if (sink_stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            sink_stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!sink_calm) begin
               case ($urandom_range(0, 19)) inside
                  [0:3]: sink_stall_left = $urandom_range(1, 3);
                  4: sink_stall_left = $urandom_range(10, 40);
                  default: sink_stall_left = 0;
               endcase
            end
         end
      end
   end

   // Long receiver hold-off, so that the core sits with a finished response
   // while the sender keeps a request waiting.
   initial begin
      forever begin
         @(hold_trigger);
         long_hold <= 1'b1;
         repeat (LONG_HOLD_CYCLES) @(posedge clock);
         long_hold <= 1'b0;
      end
   end

   initial begin
      int phase;
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.op       <= OP_OFFER;
      req_bus.key      <= '0;
      req_bus.item_id  <= '0;
      req_bus.position <= '0;
      csr_bus.valid    <= 1'b0;
      csr_bus.data     <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset ordering is smallest first. Typed rows are read straight off
      // the list; the rest go through the shadow model.
      directed_rows.push_back(row(OP_POLL,       0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(row(OP_READ,       0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(row(OP_REMOVE_AT,  0, 0, 31, 1, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(row(OP_REMOVE_ID,  0, ID_MAX, 0, 1, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(row(OP_RSVD_LO,    KEY_MAX, ID_MAX, 31, 1, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(row(OP_RSVD_HI,    0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(row(OP_OFFER, 16'h8000, 16'h1234, 0, 1, 1, 0, 0, 0, 0, 1, 0));
      directed_rows.push_back(row(OP_OFFER, KEY_MAX, ID_MAX, 31, 1, 1, 1, 0, 0, 0, 2, 0));
      directed_rows.push_back(row(OP_OFFER, 0, 0, 0, 1, 1, 0, 0, 0, 0, 3, 0));
      // Equal key goes ahead of the stored one.
      directed_rows.push_back(row(OP_OFFER, 16'h8000, 16'hABCD, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(row(OP_READ, 0, 0, 3, 1, 1, 0, ID_MAX, KEY_MAX, 0, 4, 0));
      directed_rows.push_back(row(OP_READ, 0, 0, 4, 1, 0, 0, 0, 0, 0, 4, 0));
      directed_rows.push_back(row(OP_READ, 0, 0, 31, 1, 0, 0, 0, 0, 0, 4, 0));
      directed_rows.push_back(row(OP_REMOVE_AT, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(row(OP_REMOVE_AT, 0, 0, 31, 1, 0, 0, 0, 0, 0, 3, 0));
      directed_rows.push_back(row(OP_OFFER, 16'h8000, ID_MAX, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(row(OP_REMOVE_ID, 0, ID_MAX, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(row(OP_REMOVE_ID, 0, 16'h5555, 0, 1, 0, 0, 0, 0, 0, 2, 0));
      directed_rows.push_back(row(OP_POLL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(row(OP_RSVD_MID, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1, 0));
      directed_rows.push_back(row(OP_POLL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(row(OP_POLL, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
      foreach (directed_rows[n])
         send(directed_rows[n].req, directed_rows[n].typed, directed_rows[n].res);

      for (phase = 0; phase < 4; phase++) begin
         wait_for_results();
         write_largest_first(ORDER_PLAN[phase]);
         items_left = ITEMS_PER_PHASE;
         if (phase == 1) -> hold_trigger;
         while (items_left > 0) run_episode();
      end

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("sorted_priority_queue_core regression: pass");
      end else begin
         $display("sorted_priority_queue_core regression: fail");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_if.sv
rtl/spq_cmp.sv
rtl/spq_store.sv
rtl/spq_seq.sv
rtl/sorted_priority_queue_core.sv
verif/tb_top.sv
